/* rtl/core/ped_pkg.sv */
// Shared constants for the pairwise Euclidean distance block.
// Field widths, register defaults and request/status codes.
// No dependencies.
`default_nettype none

package ped_pkg;

  localparam int PIDX_W     = 6;
  localparam int DIDX_W     = 4;
  localparam int COORD_IN_W = 16;
  localparam int DIST_W     = 18;
  localparam int PTS_CFG_W  = 7;
  localparam int DIMS_CFG_W = 5;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [DIST_W-1:0]     DIST_MAX   = '1;
  localparam logic [PTS_CFG_W-1:0]  PTS_RESET  = 7'd64;
  localparam logic [DIMS_CFG_W-1:0] DIMS_RESET = 5'd16;

  // request type
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result status
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  // register select (paddr bit 2)
  localparam logic REG_POINTS = 1'b0;
  localparam logic REG_DIMS   = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/ped_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on ped_pkg for field widths.
`default_nettype none

interface ped_req_if;
  import ped_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [PIDX_W-1:0]            point_index;
  logic [DIDX_W-1:0]            dim_index;
  logic signed [COORD_IN_W-1:0] coord_value;
  logic [PIDX_W-1:0]            other_point_index;

  modport source (
    output valid, req_type, point_index, dim_index, coord_value, other_point_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, point_index, dim_index, coord_value, other_point_index,
    output ready
  );
endinterface

interface ped_rsp_if;
  import ped_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              status;

  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

`default_nettype wire

/* rtl/core/ped_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
`default_nettype none

module ped_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_a_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_b_i,
  output logic [WIDTH-1:0]          rdata_a_o,
  output logic [WIDTH-1:0]          rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* rtl/core/pairwise_euclidean_distance_top.sv */
// Pairwise Euclidean distance over a RAM of fixed-point point coordinates.
// Depends on ped_pkg, ped_req_if / ped_rsp_if and ped_ram.
//
// Usage:
//   req_i beats either write one coordinate (req_type = write) or ask for
//   the distance between point_index and other_point_index (req_type =
//   query). rsp_o carries one beat per query: floor distance in Q18.0 and a
//   status that flags a point index at or beyond points_in_use (distance 0).
//   Writes give no result; out-of-range writes are dropped.
//   APB registers: 0x0 points_in_use, 0x4 dims_in_use; pready is tied high.
// Timing:
//   A write is accepted without leaving idle. A query keeps req_i.ready low
//   until its result is loaded: one dimension pair per cycle through the
//   dual-read RAM, a three-stage diff/square/accumulate pipe, then a
//   digit-by-digit square root that retires one result bit per cycle.
//   A range error skips from idle straight to the final state.
// Reset clears the registers to 64 points and 16 dims; the coordinate RAM
// is not cleared and must be written before it is queried.
// The result sits in an output register; requests are taken while it
// waits, and a finished query stalls in its last state until rsp_o frees.
`default_nettype none

module pairwise_euclidean_distance_top #(
  parameter int MAX_POINTS  = 64,
  parameter int MAX_DIMS    = 16,
  parameter int COORD_WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  ped_req_if.sink                      req_i,
  ped_rsp_if.source                    rsp_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [ped_pkg::APB_AW-1:0]    paddr,
  input  wire [ped_pkg::APB_DW-1:0]    pwdata,
  output logic [ped_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import ped_pkg::*;

  localparam int SW       = (COORD_WIDTH < COORD_IN_W) ? COORD_WIDTH : COORD_IN_W;
  localparam int PB       = $clog2(MAX_POINTS);
  localparam int DB       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW       = PB + DB;
  localparam int DEPTH    = MAX_POINTS * (2 ** DB);
  localparam int NPC_W    = $clog2(MAX_POINTS + 1);
  localparam int DIMC_W   = $clog2(MAX_DIMS + 1);
  localparam int SQ_W     = 2 * SW;
  localparam int SUM_W    = SQ_W + DIMC_W;
  localparam int SQ_STEPS = (SUM_W + 1) / 2;
  localparam int RT_W     = SQ_STEPS;
  localparam int X_W      = 2 * SQ_STEPS;
  localparam int SQC_W    = $clog2(SQ_STEPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_SQRT,
    ST_FIN
  } state_e;

  state_e                  state_q;
  logic [PTS_CFG_W-1:0]    pts_q;
  logic [DIMS_CFG_W-1:0]   dims_q;
  logic [DIMC_W-1:0]       k_q;
  logic [SQC_W-1:0]        step_q;
  logic                    v1_q, v2_q, v3_q;
  logic                    out_valid_q;
  logic [DIST_W-1:0]       out_dist_q;
  logic                    out_status_q;

  logic [PB-1:0]           pa_q, pb_q;
  logic [DIMC_W-1:0]       ndim_q;
  logic                    res_err_q;
  logic [SW-1:0]           mag_q;
  logic [SQ_W-1:0]         sq_q;
  logic [SUM_W-1:0]        sum_q;
  logic [X_W-1:0]          x_q;
  logic [RT_W+1:0]         rem_q;
  logic [RT_W-1:0]         root_q;

  logic                    req_fire;
  logic                    cfg_wr;
  logic [NPC_W-1:0]        pts_eff;
  logic [DIMC_W-1:0]       dims_eff;
  logic                    q_err;
  logic                    wr_en;
  logic                    issue;
  logic                    acc_done;
  logic                    out_load;
  logic [AW-1:0]           waddr, raddr_a, raddr_b;
  logic [SW-1:0]           rd_a, rd_b;
  logic signed [SW:0]      diff_w;
  logic [SW-1:0]           mag_w;
  logic [SQ_W-1:0]         sq_w;
  logic [RT_W+2:0]         rem_sh, trial;
  logic                    ge;
  logic [DIST_W-1:0]       root_sat;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_wr      = psel && penable && pwrite;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIMS) ? APB_DW'(dims_q) : APB_DW'(pts_q);

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.distance = out_dist_q;
  assign rsp_o.status   = out_status_q;

  assign pts_eff  = (32'(pts_q) > 32'(MAX_POINTS)) ? NPC_W'(MAX_POINTS) : NPC_W'(pts_q);
  assign dims_eff = (32'(dims_q) > 32'(MAX_DIMS)) ? DIMC_W'(MAX_DIMS) : DIMC_W'(dims_q);

  assign q_err = (32'(req_i.point_index) >= 32'(pts_eff)) ||
                 (32'(req_i.other_point_index) >= 32'(pts_eff));

  assign wr_en = req_fire && (req_i.req_type == REQ_WRITE) &&
                 (32'(req_i.point_index) < 32'(MAX_POINTS)) &&
                 (32'(req_i.dim_index) < 32'(MAX_DIMS));
  assign waddr = {PB'(req_i.point_index), DB'(req_i.dim_index)};

  // one dimension pair read per cycle
  assign issue    = (state_q == ST_ACC) && (k_q != ndim_q);
  assign raddr_a  = {pa_q, k_q[DB-1:0]};
  assign raddr_b  = {pb_q, k_q[DB-1:0]};
  assign acc_done = (state_q == ST_ACC) && (k_q == ndim_q) && !v1_q && !v2_q && !v3_q;

  // result register takes the finished query when empty or draining
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);

  ped_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (waddr),
    .wdata_i   (req_i.coord_value[SW-1:0]),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // |a - b| always fits SW bits
  assign diff_w = $signed({rd_a[SW-1], rd_a}) - $signed({rd_b[SW-1], rd_b});
  assign mag_w  = diff_w[SW] ? SW'(-diff_w) : SW'(diff_w);
  assign sq_w   = mag_q * mag_q;

  // digit-by-digit square root, two radicand bits per step
  assign rem_sh   = {rem_q[RT_W:0], x_q[X_W-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign root_sat = (32'(root_q) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pts_q        <= PTS_RESET;
      dims_q       <= DIMS_RESET;
      k_q          <= '0;
      step_q       <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      out_dist_q   <= '0;
      out_status_q <= STAT_OK;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_POINTS: pts_q  <= pwdata[PTS_CFG_W-1:0];
          REG_DIMS:   dims_q <= pwdata[DIMS_CFG_W-1:0];
          default: ;
        endcase
      end

      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;

      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_dist_q   <= res_err_q ? '0 : root_sat;
        out_status_q <= res_err_q ? STAT_RANGE : STAT_OK;
      end else if (rsp_o.valid && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_fire && (req_i.req_type == REQ_QUERY)) begin
            k_q     <= '0;
            state_q <= q_err ? ST_FIN : ST_ACC;
          end
        end
        ST_ACC: begin
          if (issue) begin
            k_q <= k_q + 1'b1;
          end
          if (acc_done) begin
            step_q  <= '0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          step_q <= step_q + 1'b1;
          if (step_q == SQC_W'(SQ_STEPS - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      pa_q      <= PB'(req_i.point_index);
      pb_q      <= PB'(req_i.other_point_index);
      ndim_q    <= dims_eff;
      res_err_q <= q_err;
      sum_q     <= '0;
    end
    if (v1_q) begin
      mag_q <= mag_w;
    end
    if (v2_q) begin
      sq_q <= sq_w;
    end
    if (v3_q) begin
      sum_q <= sum_q + SUM_W'(sq_q);
    end
    if (acc_done) begin
      x_q    <= X_W'(sum_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == ST_SQRT) begin
      x_q    <= x_q << 2;
      rem_q  <= ge ? (RT_W+2)'(rem_sh - trial) : (RT_W+2)'(rem_sh);
      root_q <= {root_q[RT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire
